FILE: src/lcbe_pkg.sv
package lcbe_pkg;

    localparam int MAX_CELLS     = 1024;
    localparam int CELL_CAPACITY = 16;
    localparam int ID_BITS       = 12;
    localparam int IDX_W         = $clog2(MAX_CELLS);
    localparam int SLOT_W        = $clog2(CELL_CAPACITY);
    localparam int CNT_W         = $clog2(CELL_CAPACITY + 1);
    localparam int ADDR_W        = IDX_W + SLOT_W;
    localparam int DIM_W         = 11;
    localparam int POS_W         = 32;
    localparam int SIZE_W        = 31;
    localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_MOVE   = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam logic [2:0] STAT_DONE     = 3'd0;
    localparam logic [2:0] STAT_LEFT     = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_NEIGHBOR = 3'd3;
    localparam logic [2:0] STAT_EMPTY    = 3'd4;

    localparam logic [2:0] REG_CORNER_X  = 3'd0;
    localparam logic [2:0] REG_CORNER_Y  = 3'd1;
    localparam logic [2:0] REG_CORNER_Z  = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE = 3'd3;
    localparam logic [2:0] REG_CELLS_X   = 3'd4;
    localparam logic [2:0] REG_CELLS_Y   = 3'd5;
    localparam logic [2:0] REG_CELLS_Z   = 3'd6;
    localparam logic [2:0] REG_THREE_D   = 3'd7;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_LOC_SUB,
        S_LOC_DIV,
        S_LIN_A,
        S_LIN_B,
        S_LIN_C,
        S_LIN_D,
        S_RM_OCC,
        S_RM_CNT,
        S_RM_RD,
        S_RM_CMP,
        S_PL_OCC,
        S_PL_DO,
        S_Q_STEP,
        S_Q_CAP,
        S_Q_FIN
    } state_t;

    typedef struct packed {
        logic               occ_re;
        logic               occ_we;
        logic [IDX_W-1:0]   occ_addr;
        logic [CNT_W-1:0]   occ_wdata;
        logic               mem_re;
        logic               mem_we;
        logic [ADDR_W-1:0]  mem_addr;
        logic [ID_BITS-1:0] mem_wdata;
    } store_req_t;

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = 11'd1;
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

endpackage

FILE: src/lcbe_div.sv
module lcbe_div
    import lcbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [POS_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [POS_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [POS_W-1:0]  quo_reg, quo_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;
    logic [POS_W-1:0]  shifted;
    logic [POS_W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg[POS_W-2:0], quo_reg[POS_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(POS_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = (divisor == '0) ? SIZE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[POS_W])
            begin
                rem_next = diff[POS_W-1:0];
            end
            else
            begin
                rem_next = shifted;
            end
            quo_next = {quo_reg[POS_W-2:0], ~diff[POS_W]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/lcbe_store.sv
module lcbe_store
    import lcbe_pkg::*;
(
    input  logic               clk,
    input  store_req_t         req,
    output logic [CNT_W-1:0]   occ_rdata,
    output logic [ID_BITS-1:0] mem_rdata
);

    logic [CNT_W-1:0]   occ_mem [0:MAX_CELLS-1];
    logic [ID_BITS-1:0] id_mem  [0:MAX_CELLS*CELL_CAPACITY-1];
    logic [CNT_W-1:0]   occ_rd_reg;
    logic [ID_BITS-1:0] mem_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.occ_we)
        begin
            occ_mem[req.occ_addr] <= req.occ_wdata;
        end
        if (req.occ_re)
        begin
            occ_rd_reg <= occ_mem[req.occ_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.mem_we)
        begin
            id_mem[req.mem_addr] <= req.mem_wdata;
        end
        if (req.mem_re)
        begin
            mem_rd_reg <= id_mem[req.mem_addr];
        end
    end

    assign occ_rdata = occ_rd_reg;
    assign mem_rdata = mem_rd_reg;

endmodule

FILE: src/linked_cell_binning_engine_top.sv
// Linked-cell binning engine: a grid of cells, each with a list of up to 16 particle ids.
// Command channel: put command, particle_id, pos_* and old_* on the ports and raise start;
// the word is taken at a clock edge with start high and busy low. One word is in flight at
// a time; busy drops in the cycle that shows the last result of that word.
// Result channel: each result word is valid for one cycle while strobe is high; last
// marks the final word of a command. The receiver cannot stall and must take every word.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge; the user must
// write only while idle; the block itself does not enforce it. Command time is set by
// one shared radix-2 divider, used per axis coordinate after a subtract step, and by the
// single-port cell memories. Steps until the last result is shown, for one cycle:
//   insert: locate each axis (three in 3D, two in 2D), then place the id or report full
//   move:   locate the old cell and read each id held there to drop this id, then insert
//   query:  locate, then step through the neighbor offsets, 27 offsets in total
//   clear:  sweep all 1024 cell counts, one count cleared per cycle
// A position outside the grid ends the command early, at the first axis that fails or
// at a cell index of 1024 or more; for move, an old position outside only skips removal.
// After reset all 1024 cell counts are swept to zero, busy high; config writes are taken.
module linked_cell_binning_engine_top
    import lcbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [1:0]          command,
    input  logic [ID_BITS-1:0]  particle_id,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  old_x,
    input  logic signed [31:0]  old_y,
    input  logic signed [31:0]  old_z,
    output logic                strobe,
    output logic [2:0]          status,
    output logic [IDX_W-1:0]    cell_index,
    output logic [CNT_W-1:0]    cell_count,
    output logic                last
);

    state_t state_reg, state_next;

    logic signed [31:0] corner_x_reg, corner_y_reg, corner_z_reg;
    logic [SIZE_W-1:0]  cell_size_reg;
    logic [DIM_W-1:0]   cells_x_reg, cells_y_reg, cells_z_reg;
    logic               three_d_reg;

    cmd_t               cmd_reg;
    logic [ID_BITS-1:0] id_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg, ox_reg, oy_reg, oz_reg;

    logic               old_reg, old_next;
    logic [1:0]         axis_reg, axis_next;
    logic [IDX_W-1:0]   ci_reg, ci_next, cj_reg, cj_next, ck_reg, ck_next;
    logic [20:0]        nxny_reg, nxny_next;
    logic [31:0]        lin_reg, lin_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   r_reg, r_next, w_reg, w_next;
    logic [1:0]         qi_reg, qi_next, qj_reg, qj_next, qk_reg, qk_next;
    logic [IDX_W-1:0]   qidx_reg, qidx_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic [CNT_W-1:0]   pcnt_reg, pcnt_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;

    logic               strobe_reg, strobe_next;
    logic [2:0]         status_reg, status_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               last_reg, last_next;

    store_req_t         req;
    logic [CNT_W-1:0]   occ_rdata;
    logic [ID_BITS-1:0] mem_rdata;

    logic               div_start, div_done;
    logic [POS_W-1:0]   quotient;

    logic [DIM_W-1:0]   nx, ny, nz, n_sel;
    logic signed [31:0] pos_sel, cor_sel;
    logic signed [32:0] d_sel;
    logic               q_fail;
    logic               ok_i, ok_j, ok_k, center, at_end, q_hit;
    logic signed [33:0] off_i, off_j, off_k, lin_n;
    logic               accept;

    assign accept = start && (state_reg == S_IDLE);
    assign nx     = dim_clamp(cells_x_reg);
    assign ny     = dim_clamp(cells_y_reg);
    assign nz     = three_d_reg ? dim_clamp(cells_z_reg) : DIM_W'(1);

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                pos_sel = old_reg ? ox_reg : px_reg;
                cor_sel = corner_x_reg;
                n_sel   = nx;
            end
            AXIS_Y:
            begin
                pos_sel = old_reg ? oy_reg : py_reg;
                cor_sel = corner_y_reg;
                n_sel   = ny;
            end
            default:
            begin
                pos_sel = old_reg ? oz_reg : pz_reg;
                cor_sel = corner_z_reg;
                n_sel   = nz;
            end
        endcase
        d_sel  = 33'(pos_sel) - 33'(cor_sel);
        q_fail = quotient >= POS_W'(n_sel);
    end

    always_comb
    begin
        ok_i   = !((qi_reg == 2'd0) && (ci_reg == '0)) &&
                 !((qi_reg == 2'd2) && ((DIM_W'(ci_reg) + DIM_W'(1)) >= nx));
        ok_j   = !((qj_reg == 2'd0) && (cj_reg == '0)) &&
                 !((qj_reg == 2'd2) && ((DIM_W'(cj_reg) + DIM_W'(1)) >= ny));
        ok_k   = !((qk_reg == 2'd0) && (ck_reg == '0)) &&
                 !((qk_reg == 2'd2) && ((DIM_W'(ck_reg) + DIM_W'(1)) >= nz));
        center = (qi_reg == 2'd1) && (qj_reg == 2'd1) && (qk_reg == 2'd1);
        at_end = (qi_reg == 2'd2) && (qj_reg == 2'd2) && (qk_reg == 2'd2);
        off_i  = (qi_reg == 2'd0) ? -34'sd1 : ((qi_reg == 2'd2) ? 34'sd1 : 34'sd0);
        off_j  = (qj_reg == 2'd0) ? -$signed({23'd0, nx}) :
                 ((qj_reg == 2'd2) ? $signed({23'd0, nx}) : 34'sd0);
        off_k  = (qk_reg == 2'd0) ? -$signed({13'd0, nxny_reg}) :
                 ((qk_reg == 2'd2) ? $signed({13'd0, nxny_reg}) : 34'sd0);
        lin_n  = $signed({24'd0, idx_reg}) + off_i + off_j + off_k;
        q_hit  = ok_i && ok_j && ok_k && !center && (lin_n[33:IDX_W] == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (clr_reg == IDX_W'(MAX_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd_t'(command) == CMD_CLEAR) ? S_CLEAR : S_LOC_SUB;
                end
            end
            S_CLEAR:
            begin
                if (clr_reg == IDX_W'(MAX_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOC_SUB:
            begin
                if (d_sel[32])
                begin
                    state_next = old_reg ? S_LOC_SUB : S_IDLE;
                end
                else
                begin
                    state_next = S_LOC_DIV;
                end
            end
            S_LOC_DIV:
            begin
                if (div_done)
                begin
                    if (q_fail)
                    begin
                        state_next = old_reg ? S_LOC_SUB : S_IDLE;
                    end
                    else if ((axis_reg == AXIS_X) || ((axis_reg == AXIS_Y) && three_d_reg))
                    begin
                        state_next = S_LOC_SUB;
                    end
                    else
                    begin
                        state_next = S_LIN_A;
                    end
                end
            end
            S_LIN_A: state_next = S_LIN_B;
            S_LIN_B: state_next = S_LIN_C;
            S_LIN_C: state_next = S_LIN_D;
            S_LIN_D:
            begin
                if (lin_reg >= 32'(MAX_CELLS))
                begin
                    state_next = old_reg ? S_LOC_SUB : S_IDLE;
                end
                else if (old_reg)
                begin
                    state_next = S_RM_OCC;
                end
                else if (cmd_reg == CMD_QUERY)
                begin
                    state_next = S_Q_STEP;
                end
                else
                begin
                    state_next = S_PL_OCC;
                end
            end
            S_RM_OCC: state_next = S_RM_CNT;
            S_RM_CNT: state_next = S_RM_RD;
            S_RM_RD:  state_next = (r_reg < cnt_reg) ? S_RM_CMP : S_LOC_SUB;
            S_RM_CMP: state_next = S_RM_RD;
            S_PL_OCC: state_next = S_PL_DO;
            S_PL_DO:  state_next = S_IDLE;
            S_Q_STEP:
            begin
                if (q_hit)
                begin
                    state_next = S_Q_CAP;
                end
                else if (at_end)
                begin
                    state_next = S_Q_FIN;
                end
            end
            S_Q_CAP:  state_next = at_end ? S_Q_FIN : S_Q_STEP;
            S_Q_FIN:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        old_next    = old_reg;
        axis_next   = axis_reg;
        ci_next     = ci_reg;
        cj_next     = cj_reg;
        ck_next     = ck_reg;
        nxny_next   = nxny_reg;
        lin_next    = lin_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        qi_next     = qi_reg;
        qj_next     = qj_reg;
        qk_next     = qk_reg;
        qidx_next   = qidx_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        pcnt_next   = pcnt_reg;
        clr_next    = clr_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        div_start   = 1'b0;
        req         = '0;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                req.occ_we   = 1'b1;
                req.occ_addr = clr_reg;
                clr_next     = clr_reg + IDX_W'(1);
                if ((state_reg == S_CLEAR) && (clr_reg == IDX_W'(MAX_CELLS - 1)))
                begin
                    strobe_next = 1'b1;
                    status_next = STAT_DONE;
                    index_next  = '0;
                    count_next  = '0;
                    last_next   = 1'b1;
                end
            end
            S_IDLE:
            begin
                old_next  = (cmd_t'(command) == CMD_MOVE);
                axis_next = AXIS_X;
                clr_next  = '0;
            end
            S_LOC_SUB:
            begin
                if (d_sel[32])
                begin
                    if (old_reg)
                    begin
                        old_next  = 1'b0;
                        axis_next = AXIS_X;
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                        status_next = STAT_LEFT;
                        index_next  = '0;
                        count_next  = '0;
                        last_next   = 1'b1;
                    end
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            S_LOC_DIV:
            begin
                if (div_done)
                begin
                    if (q_fail)
                    begin
                        if (old_reg)
                        begin
                            old_next  = 1'b0;
                            axis_next = AXIS_X;
                        end
                        else
                        begin
                            strobe_next = 1'b1;
                            status_next = STAT_LEFT;
                            index_next  = '0;
                            count_next  = '0;
                            last_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        unique case (axis_reg)
                            AXIS_X:
                            begin
                                ci_next   = quotient[IDX_W-1:0];
                                axis_next = AXIS_Y;
                            end
                            AXIS_Y:
                            begin
                                cj_next   = quotient[IDX_W-1:0];
                                ck_next   = '0;
                                axis_next = AXIS_Z;
                            end
                            default:
                            begin
                                ck_next = quotient[IDX_W-1:0];
                            end
                        endcase
                    end
                end
            end
            S_LIN_A:
            begin
                nxny_next = 21'(nx) * 21'(ny);
            end
            S_LIN_B:
            begin
                lin_next = 32'(ci_reg) + 32'(cj_reg) * 32'(nx);
            end
            S_LIN_C:
            begin
                lin_next = lin_reg + 32'(ck_reg) * 32'(nxny_reg);
            end
            S_LIN_D:
            begin
                idx_next  = lin_reg[IDX_W-1:0];
                r_next    = '0;
                w_next    = '0;
                qi_next   = 2'd0;
                qj_next   = 2'd0;
                qk_next   = 2'd0;
                pend_next = 1'b0;
                if (lin_reg >= 32'(MAX_CELLS))
                begin
                    if (old_reg)
                    begin
                        old_next  = 1'b0;
                        axis_next = AXIS_X;
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                        status_next = STAT_LEFT;
                        index_next  = '0;
                        count_next  = '0;
                        last_next   = 1'b1;
                    end
                end
            end
            S_RM_OCC, S_PL_OCC:
            begin
                req.occ_re   = 1'b1;
                req.occ_addr = idx_reg;
            end
            S_RM_CNT:
            begin
                cnt_next = occ_rdata;
            end
            S_RM_RD:
            begin
                if (r_reg < cnt_reg)
                begin
                    req.mem_re   = 1'b1;
                    req.mem_addr = {idx_reg, r_reg[SLOT_W-1:0]};
                end
                else
                begin
                    req.occ_we    = 1'b1;
                    req.occ_addr  = idx_reg;
                    req.occ_wdata = w_reg;
                    old_next      = 1'b0;
                    axis_next     = AXIS_X;
                end
            end
            S_RM_CMP:
            begin
                if (mem_rdata != id_reg)
                begin
                    req.mem_we    = 1'b1;
                    req.mem_addr  = {idx_reg, w_reg[SLOT_W-1:0]};
                    req.mem_wdata = mem_rdata;
                    w_next        = w_reg + CNT_W'(1);
                end
                r_next = r_reg + CNT_W'(1);
            end
            S_PL_DO:
            begin
                strobe_next = 1'b1;
                index_next  = idx_reg;
                last_next   = 1'b1;
                if (occ_rdata >= CNT_W'(CELL_CAPACITY))
                begin
                    status_next = STAT_FULL;
                    count_next  = occ_rdata;
                end
                else
                begin
                    req.mem_we    = 1'b1;
                    req.mem_addr  = {idx_reg, occ_rdata[SLOT_W-1:0]};
                    req.mem_wdata = id_reg;
                    req.occ_we    = 1'b1;
                    req.occ_addr  = idx_reg;
                    req.occ_wdata = occ_rdata + CNT_W'(1);
                    status_next   = STAT_DONE;
                    count_next    = occ_rdata + CNT_W'(1);
                end
            end
            S_Q_STEP, S_Q_CAP:
            begin
                if ((state_reg == S_Q_STEP) && q_hit)
                begin
                    req.occ_re   = 1'b1;
                    req.occ_addr = lin_n[IDX_W-1:0];
                    qidx_next    = lin_n[IDX_W-1:0];
                end
                else
                begin
                    if (state_reg == S_Q_CAP)
                    begin
                        if (pend_reg)
                        begin
                            strobe_next = 1'b1;
                            status_next = STAT_NEIGHBOR;
                            index_next  = pidx_reg;
                            count_next  = pcnt_reg;
                            last_next   = 1'b0;
                        end
                        pend_next = 1'b1;
                        pidx_next = qidx_reg;
                        pcnt_next = occ_rdata;
                    end
                    if (qk_reg == 2'd2)
                    begin
                        qk_next = 2'd0;
                        if (qj_reg == 2'd2)
                        begin
                            qj_next = 2'd0;
                            qi_next = qi_reg + 2'd1;
                        end
                        else
                        begin
                            qj_next = qj_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        qk_next = qk_reg + 2'd1;
                    end
                end
            end
            S_Q_FIN:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (pend_reg)
                begin
                    status_next = STAT_NEIGHBOR;
                    index_next  = pidx_reg;
                    count_next  = pcnt_reg;
                end
                else
                begin
                    status_next = STAT_EMPTY;
                    index_next  = idx_reg;
                    count_next  = '0;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            strobe_reg    <= 1'b0;
            corner_x_reg  <= '0;
            corner_y_reg  <= '0;
            corner_z_reg  <= '0;
            cell_size_reg <= SIZE_W'(65536);
            cells_x_reg   <= DIM_W'(8);
            cells_y_reg   <= DIM_W'(8);
            cells_z_reg   <= DIM_W'(8);
            three_d_reg   <= 1'b1;
            old_reg       <= 1'b0;
            axis_reg      <= AXIS_X;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            strobe_reg <= strobe_next;
            old_reg    <= old_next;
            axis_reg   <= axis_next;
            pend_reg   <= pend_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CORNER_X:  corner_x_reg  <= cfg_data;
                    REG_CORNER_Y:  corner_y_reg  <= cfg_data;
                    REG_CORNER_Z:  corner_z_reg  <= cfg_data;
                    REG_CELL_SIZE: cell_size_reg <= cfg_data[SIZE_W-1:0];
                    REG_CELLS_X:   cells_x_reg   <= cfg_data[DIM_W-1:0];
                    REG_CELLS_Y:   cells_y_reg   <= cfg_data[DIM_W-1:0];
                    REG_CELLS_Z:   cells_z_reg   <= cfg_data[DIM_W-1:0];
                    default:       three_d_reg   <= cfg_data[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            id_reg  <= particle_id;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            ox_reg  <= old_x;
            oy_reg  <= old_y;
            oz_reg  <= old_z;
        end
        ci_reg     <= ci_next;
        cj_reg     <= cj_next;
        ck_reg     <= ck_next;
        nxny_reg   <= nxny_next;
        lin_reg    <= lin_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        r_reg      <= r_next;
        w_reg      <= w_next;
        qi_reg     <= qi_next;
        qj_reg     <= qj_next;
        qk_reg     <= qk_next;
        qidx_reg   <= qidx_next;
        pidx_reg   <= pidx_next;
        pcnt_reg   <= pcnt_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    lcbe_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d_sel[POS_W-1:0]),
        .divisor  (cell_size_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    lcbe_store u_store
    (
        .clk       (clk),
        .req       (req),
        .occ_rdata (occ_rdata),
        .mem_rdata (mem_rdata)
    );

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign cell_index = index_reg;
    assign cell_count = count_reg;
    assign last       = last_reg;

endmodule
